/* rtl/itf_pkg.sv */
`timescale 1ns / 1ps

package itf_pkg;

    // Sizes of the fixed fields
    localparam int ITF_MAX_FIELD = 64;
    localparam int NUM_W         = 32;
    localparam int CHAR_W        = 8;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 7;
    localparam int FW_W          = 7;
    localparam int DIG_N         = 32;
    localparam int DIG_W         = 4;
    localparam int DIG_IDX_W     = 5;
    localparam int ND_W          = 6;
    localparam int BCD_DIGITS    = 10;
    localparam int VAL_W         = BCD_DIGITS * DIG_W;
    localparam int BCD_CNT_W     = 5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FORMAT_TYPE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIGN_MODE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EXACT_PREFIX = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_ALIGN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_PAD     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FIELD_WIDTH  = 3'd5;

    // Sign mode codes
    localparam logic [1:0] SM_NONE  = 2'd0;
    localparam logic [1:0] SM_SPACE = 2'd1;
    localparam logic [1:0] SM_PLUS  = 2'd2;

    // Characters
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CH_DOLLAR  = 8'h24;
    localparam logic [CHAR_W-1:0] CH_PERCENT = 8'h25;
    localparam logic [CHAR_W-1:0] CH_AMP     = 8'h26;
    localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_A_UP    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_A_LO    = 8'h61;

    typedef enum logic [2:0] {
        FT_NONE,
        FT_SDEC,
        FT_UDEC,
        FT_HEX_UP,
        FT_HEX_LO,
        FT_BIN,
        FT_OCT,
        FT_STR
    } t_ftype;

    typedef enum logic [1:0] {
        RX_DEC,
        RX_HEX,
        RX_BIN,
        RX_OCT
    } t_radix;

    typedef struct packed {
        t_ftype          format_type;
        logic [1:0]      sign_mode;
        logic            exact_prefix;
        logic            left_align;
        logic            zero_pad;
        logic [FW_W-1:0] field_width;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BCD,
        ST_DIGIT,
        ST_LAYOUT,
        ST_EMIT
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic bcd_step;
        logic dig_step;
        logic layout;
        logic emit;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic is_dec;
        logic bcd_last;
        logic dig_last;
        logic out_free;
        logic emit_last;
    } t_stat;

endpackage

/* rtl/itf_num_if.sv */
`timescale 1ns / 1ps

interface itf_num_if;
    logic                        valid;
    logic                        ready;
    logic [itf_pkg::NUM_W-1:0]   number;

    modport source (output valid, output number, input ready);
    modport sink   (input valid, input number, output ready);
endinterface

/* rtl/itf_txt_if.sv */
`timescale 1ns / 1ps

interface itf_txt_if;
    logic                        valid;
    logic                        ready;
    logic [itf_pkg::CHAR_W-1:0]  text_char;
    logic                        last_char;
    logic                        misuse;

    modport source (output valid, output text_char, output last_char, output misuse,
                    input ready);
    modport sink   (input valid, input text_char, input last_char, input misuse,
                    output ready);
endinterface

/* rtl/itf_cfg.sv */
`timescale 1ns / 1ps

module itf_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_we,
    input  logic [itf_pkg::CFG_IDX_W-1:0]    i_idx,
    input  logic [itf_pkg::CFG_DATA_W-1:0]   i_data,
    output itf_pkg::t_cfg                    o_cfg
);
    import itf_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Register write decode; unknown indexes leave everything alone.
    always_comb begin
        n_cfg = r_cfg;
        if (i_we) begin
            case (i_idx)
                REG_FORMAT_TYPE:  n_cfg.format_type  = t_ftype'(i_data[2:0]);
                REG_SIGN_MODE:    n_cfg.sign_mode    = i_data[1:0];
                REG_EXACT_PREFIX: n_cfg.exact_prefix = i_data[0];
                REG_LEFT_ALIGN:   n_cfg.left_align   = i_data[0];
                REG_ZERO_PAD:     n_cfg.zero_pad     = i_data[0];
                REG_FIELD_WIDTH:  n_cfg.field_width  = i_data[FW_W-1:0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/itf_ctrl.sv */
`timescale 1ns / 1ps

module itf_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  itf_pkg::t_stat  i_stat,
    output itf_pkg::t_cmd   o_cmd
);
    import itf_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_stat.is_dec ? ST_BCD : ST_DIGIT;
                end
            end
            ST_BCD: begin
                o_cmd.bcd_step = 1'b1;
                if (i_stat.bcd_last) begin
                    n_state = ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                o_cmd.dig_step = 1'b1;
                if (i_stat.dig_last) begin
                    n_state = ST_LAYOUT;
                end
            end
            ST_LAYOUT: begin
                o_cmd.layout = 1'b1;
                n_state      = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.emit_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/itf_dp.sv */
`timescale 1ns / 1ps

module itf_dp #(
    parameter int MAX_FIELD = itf_pkg::ITF_MAX_FIELD
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  itf_pkg::t_cfg                i_cfg,
    input  logic [itf_pkg::NUM_W-1:0]    i_number,
    input  itf_pkg::t_cmd                i_cmd,
    output itf_pkg::t_stat               o_stat,
    itf_txt_if.source                    o_txt
);
    import itf_pkg::*;

    // Width of character positions within one formatted number
    localparam int CW = $clog2(MAX_FIELD + 1);

    // Decoded format of the incoming word
    t_ftype             ty_eff;
    logic               exact_eff;
    logic               is_dec;
    logic               neg;
    logic [NUM_W-1:0]   mag;

    // Working registers
    logic [NUM_W-1:0]   r_bin,     n_bin;
    logic [VAL_W-1:0]   r_val,     n_val;
    logic [BCD_CNT_W-1:0] r_cnt,   n_cnt;
    logic [ND_W-1:0]    r_nd,      n_nd;
    logic [DIG_W-1:0]   r_dig [DIG_N];
    t_radix             r_radix,   n_radix;
    logic               r_lower,   n_lower;
    logic               r_mis,     n_mis;
    logic               r_has_sign, n_has_sign;
    logic [CHAR_W-1:0]  r_sign_ch, n_sign_ch;
    logic               r_has_pfx, n_has_pfx;
    logic [CHAR_W-1:0]  r_pfx_ch,  n_pfx_ch;
    logic [CW-1:0]      r_b1, n_b1, r_b2, n_b2, r_b3, n_b3, r_b4, n_b4, r_b5, n_b5;
    logic [CW-1:0]      r_total,   n_total;
    logic [CW-1:0]      r_k,       n_k;
    logic               r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]  r_out_char,  n_out_char;
    logic               r_out_last,  n_out_last;
    logic               r_out_mis,   n_out_mis;

    // Step helpers
    logic [VAL_W-1:0]   bcd_adj;
    logic [DIG_W-1:0]   dig_new;
    logic [VAL_W-1:0]   val_sh;
    logic [CW-1:0]      w_cap;
    logic [CW-1:0]      num_len;
    logic [CW-1:0]      total;
    logic [CW-1:0]      pad;
    logic [CW-1:0]      dig_pos;
    logic [DIG_W-1:0]   dig_rd;
    logic [CHAR_W-1:0]  dig_ch;
    logic [CHAR_W-1:0]  sel_ch;

    // Type decode: no type means upper hex with the prefix forced on.
    always_comb begin
        ty_eff    = (i_cfg.format_type == FT_NONE) ? FT_HEX_UP : i_cfg.format_type;
        exact_eff = (i_cfg.format_type == FT_NONE) || i_cfg.exact_prefix;
        is_dec    = (ty_eff == FT_SDEC) || (ty_eff == FT_UDEC) || (ty_eff == FT_STR);
        neg       = (ty_eff == FT_SDEC) && i_number[NUM_W-1];
        mag       = neg ? (NUM_W'(0) - i_number) : i_number;
    end

    // Double-dabble correction: each BCD digit of five or more gets three added.
    always_comb begin
        for (int j = 0; j < BCD_DIGITS; j++) begin
            bcd_adj[j*DIG_W +: DIG_W] = (r_val[j*DIG_W +: DIG_W] >= 4'd5)
                ? r_val[j*DIG_W +: DIG_W] + 4'd3
                : r_val[j*DIG_W +: DIG_W];
        end
    end

    // Lowest digit of the working value and the value with it removed
    always_comb begin
        case (r_radix)
            RX_BIN: begin
                dig_new = {3'b000, r_val[0]};
                val_sh  = r_val >> 1;
            end
            RX_OCT: begin
                dig_new = {1'b0, r_val[2:0]};
                val_sh  = r_val >> 3;
            end
            default: begin
                dig_new = r_val[DIG_W-1:0];
                val_sh  = r_val >> DIG_W;
            end
        endcase
    end

    // Field layout: lengths of the padding and text sections
    always_comb begin
        w_cap   = (i_cfg.field_width > FW_W'(MAX_FIELD)) ? CW'(MAX_FIELD)
                                                          : CW'(i_cfg.field_width);
        num_len = CW'(r_nd) + CW'(r_has_sign) + CW'(r_has_pfx);
        total   = (w_cap > num_len) ? w_cap : num_len;
        pad     = total - num_len;
    end

    // Character at the current position
    always_comb begin
        dig_pos = r_b5 - CW'(1) - r_k;
        dig_rd  = r_dig[dig_pos[DIG_IDX_W-1:0]];
        if (dig_rd < 4'd10) begin
            dig_ch = CH_ZERO + CHAR_W'(dig_rd);
        end else begin
            dig_ch = (r_lower ? CH_A_LO : CH_A_UP) + CHAR_W'(dig_rd) - CHAR_W'(10);
        end
        if (r_k < r_b1) begin
            sel_ch = CH_SPACE;
        end else if (r_k < r_b2) begin
            sel_ch = r_sign_ch;
        end else if (r_k < r_b3) begin
            sel_ch = r_pfx_ch;
        end else if (r_k < r_b4) begin
            sel_ch = CH_ZERO;
        end else if (r_k < r_b5) begin
            sel_ch = dig_ch;
        end else begin
            sel_ch = CH_SPACE;
        end
    end

    // Next values of the working registers
    always_comb begin
        n_bin       = r_bin;
        n_val       = r_val;
        n_cnt       = r_cnt;
        n_nd        = r_nd;
        n_radix     = r_radix;
        n_lower     = r_lower;
        n_mis       = r_mis;
        n_has_sign  = r_has_sign;
        n_sign_ch   = r_sign_ch;
        n_has_pfx   = r_has_pfx;
        n_pfx_ch    = r_pfx_ch;
        n_b1        = r_b1;
        n_b2        = r_b2;
        n_b3        = r_b3;
        n_b4        = r_b4;
        n_b5        = r_b5;
        n_total     = r_total;
        n_k         = r_k;
        n_out_valid = r_out_valid;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        n_out_mis   = r_out_mis;

        // Capture the word and everything the format settles up front.
        if (i_cmd.load) begin
            n_bin     = mag;
            n_val     = is_dec ? '0 : VAL_W'(mag);
            n_cnt     = '0;
            n_nd      = '0;
            n_lower   = (ty_eff == FT_HEX_LO);
            n_mis     = (is_dec && exact_eff) || (ty_eff == FT_STR);
            n_has_pfx = 1'b0;
            n_pfx_ch  = CH_DOLLAR;
            case (ty_eff)
                FT_HEX_UP, FT_HEX_LO: begin
                    n_radix   = RX_HEX;
                    n_has_pfx = exact_eff;
                    n_pfx_ch  = CH_DOLLAR;
                end
                FT_BIN: begin
                    n_radix   = RX_BIN;
                    n_has_pfx = exact_eff;
                    n_pfx_ch  = CH_PERCENT;
                end
                FT_OCT: begin
                    n_radix   = RX_OCT;
                    n_has_pfx = exact_eff;
                    n_pfx_ch  = CH_AMP;
                end
                default: begin
                    n_radix = RX_DEC;
                end
            endcase
            if (neg) begin
                n_has_sign = 1'b1;
                n_sign_ch  = CH_MINUS;
            end else if (i_cfg.sign_mode == SM_SPACE) begin
                n_has_sign = 1'b1;
                n_sign_ch  = CH_SPACE;
            end else if (i_cfg.sign_mode == SM_PLUS) begin
                n_has_sign = 1'b1;
                n_sign_ch  = CH_PLUS;
            end else begin
                n_has_sign = 1'b0;
                n_sign_ch  = CH_SPACE;
            end
        end

        // One binary-to-BCD step per cycle, most significant bit first.
        if (i_cmd.bcd_step) begin
            n_val = {bcd_adj[VAL_W-2:0], r_bin[NUM_W-1]};
            n_bin = r_bin << 1;
            n_cnt = r_cnt + BCD_CNT_W'(1);
        end

        // One digit per cycle, least significant first.
        if (i_cmd.dig_step) begin
            n_val = val_sh;
            n_nd  = r_nd + ND_W'(1);
        end

        // Section boundaries along the output field
        if (i_cmd.layout) begin
            n_b1    = (!i_cfg.left_align && !i_cfg.zero_pad) ? pad : '0;
            n_b2    = n_b1 + CW'(r_has_sign);
            n_b3    = n_b2 + CW'(r_has_pfx);
            n_b4    = n_b3 + ((!i_cfg.left_align && i_cfg.zero_pad) ? pad : '0);
            n_b5    = n_b4 + CW'(r_nd);
            n_total = total;
            n_k     = '0;
        end

        // Output register: load a character or drop a taken one.
        if (i_cmd.emit) begin
            n_out_valid = 1'b1;
            n_out_char  = sel_ch;
            n_out_last  = (r_k == r_total - CW'(1));
            n_out_mis   = r_mis;
            n_k         = r_k + CW'(1);
        end else if (o_txt.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
        r_bin      <= n_bin;
        r_val      <= n_val;
        r_cnt      <= n_cnt;
        r_nd       <= n_nd;
        r_radix    <= n_radix;
        r_lower    <= n_lower;
        r_mis      <= n_mis;
        r_has_sign <= n_has_sign;
        r_sign_ch  <= n_sign_ch;
        r_has_pfx  <= n_has_pfx;
        r_pfx_ch   <= n_pfx_ch;
        r_b1       <= n_b1;
        r_b2       <= n_b2;
        r_b3       <= n_b3;
        r_b4       <= n_b4;
        r_b5       <= n_b5;
        r_total    <= n_total;
        r_k        <= n_k;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
        r_out_mis  <= n_out_mis;
        if (i_cmd.dig_step) begin
            r_dig[r_nd[DIG_IDX_W-1:0]] <= dig_new;
        end
    end

    // Status towards the controller
    always_comb begin
        o_stat.is_dec    = is_dec;
        o_stat.bcd_last  = (r_cnt == BCD_CNT_W'(NUM_W - 1));
        o_stat.dig_last  = (val_sh == '0);
        o_stat.out_free  = !r_out_valid || o_txt.ready;
        o_stat.emit_last = (r_k == r_total - CW'(1));
    end

    assign o_txt.valid     = r_out_valid;
    assign o_txt.text_char = r_out_char;
    assign o_txt.last_char = r_out_last;
    assign o_txt.misuse    = r_out_mis;

    // A character is only loaded when the held word is gone or leaving.
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || o_txt.ready))
        else $error("character loaded over an untaken word");

    // The position counter never runs past the field.
    a_emit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (r_k < r_total))
        else $error("character position beyond the field");

    // Every number yields between one and thirty-two digits.
    a_digit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.layout |-> ((r_nd != '0) && (r_nd <= ND_W'(DIG_N))))
        else $error("digit count out of range");

    // After the final character the next load waits for a fresh word.
    a_last_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && o_stat.emit_last) |=> !i_cmd.emit)
        else $error("character emitted after the last one");

endmodule

/* rtl/integer_to_text_formatter.sv */
`timescale 1ns / 1ps
// Per word: load, the 32-step BCD conversion (decimal types only), digit extraction
// (1 to 32 digits, least significant first), layout, then one character per cycle out of
// the output register while that register is free. A new word is taken only after the last
// character of the previous word has been loaded. Reset is synchronous and active low:
// all configuration registers clear to zero, the controller goes idle, the output empties.

module integer_to_text_formatter #(
    parameter int MAX_FIELD = itf_pkg::ITF_MAX_FIELD
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    itf_num_if.sink                          i_num,
    itf_txt_if.source                        o_txt,
    input  logic                             i_cfg_we,
    input  logic [itf_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [itf_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import itf_pkg::*;

    t_cfg  cfg;
    t_cmd  cmd;
    t_stat stat;
    logic  in_ready;

    // Configuration registers
    itf_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // Sequencer
    itf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_num.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Conversion and output datapath
    itf_dp #(
        .MAX_FIELD (MAX_FIELD)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_number (i_num.number),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_txt    (o_txt)
    );

    assign i_num.ready = in_ready;

endmodule
